@@ hw/rtl/aopc_pkg.sv @@
// Shared types and constants for the AND/OR precedence checker.
// Used by aopc_ctrl, aopc_dp and and_or_precedence_checker; no dependencies.
`timescale 1ns / 1ps

package aopc_pkg;

  // Number of tasks in the precedence tables (2..64)
  localparam int MaxTasks = 64;
  // Index into the tables and the finished set
  localparam int IdxW     = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  // Fixed port widths
  localparam int TaskIdW  = 7;
  localparam int MaskW    = 64;
  localparam int VerdictW = 3;

  // Operation codes
  localparam logic OpLoad  = 1'b0;
  localparam logic OpCheck = 1'b1;

  // Verdict codes, first failure wins except for a zero id
  typedef enum logic [VerdictW-1:0] {
    VerdictLegal    = 3'd0,
    VerdictZero     = 3'd1,
    VerdictNotRoot  = 3'd2,
    VerdictOrUnmet  = 3'd3,
    VerdictAndUnmet = 3'd4
  } verdict_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;  // write both mask tables
    logic rd_en;    // latch check item and read its masks
    logic eval_en;  // evaluate the latched check item
  } cmd_t;

endpackage

@@ hw/rtl/aopc_ctrl.sv @@
// Controller FSM of the AND/OR precedence checker.
// Sequences load and check items; depends on aopc_pkg.
`timescale 1ns / 1ps

module aopc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          operation_i,
  output logic          busy_o,
  output aopc_pkg::cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StEval
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;

  // Item accepted when idle
  assign accept = start_i && !busy_q;

  // Command decode
  assign cmd_o.load_we = accept && (operation_i == aopc_pkg::OpLoad);
  assign cmd_o.rd_en   = accept && (operation_i == aopc_pkg::OpCheck);
  assign cmd_o.eval_en = (state_q == StEval);
  assign busy_o        = busy_q;

  // State and registered busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_o.rd_en) begin
            state_q <= StEval;
            busy_q  <= 1'b1;
          end
        end
        StEval: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // Assertions
  a_rd_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> cmd_o.eval_en)
    else $error("check read not followed by evaluation");

  a_eval_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval_en |=> (!cmd_o.eval_en && !busy_o))
    else $error("evaluation longer than one cycle");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (!cmd_o.load_we && !cmd_o.rd_en))
    else $error("item taken while busy");

endmodule

@@ hw/rtl/aopc_dp.sv @@
// Datapath of the AND/OR precedence checker: mask tables, finished set,
// order state and verdict register. Depends on aopc_pkg.
`timescale 1ns / 1ps

module aopc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  aopc_pkg::cmd_t                      cmd_i,
  input  logic [aopc_pkg::TaskIdW-1:0]        task_id_i,
  input  logic [aopc_pkg::MaskW-1:0]          and_mask_i,
  input  logic [aopc_pkg::MaskW-1:0]          or_mask_i,
  input  logic                                last_in_order_i,
  output logic                                valid_o,
  output logic [aopc_pkg::VerdictW-1:0]       verdict_o
);

  localparam int N = aopc_pkg::MaxTasks;
  localparam int W = aopc_pkg::IdxW;

  // Mask tables; vld_q marks entries written since reset
  logic [N-1:0] and_mem [N];
  logic [N-1:0] or_mem  [N];
  logic [N-1:0] vld_q;

  logic         id_ok;
  logic [W-1:0] idx;

  // Latched check item and read data
  logic         id_ok_q;
  logic [W-1:0] idx_q;
  logic         last_q;
  logic [N-1:0] and_rd_q;
  logic [N-1:0] or_rd_q;
  logic         vld_rd_q;

  // Order state
  logic [N-1:0]       fin_q, fin_d;
  aopc_pkg::verdict_e ff_q, ff_d;
  logic               zs_q, zs_d;
  logic               mid_q;

  // Result
  logic               valid_q;
  aopc_pkg::verdict_e verdict_q, verdict_d;

  // Id decode
  assign id_ok = (task_id_i != '0) &&
                 (task_id_i <= aopc_pkg::TaskIdW'(N));
  assign idx   = W'(task_id_i - aopc_pkg::TaskIdW'(1));

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && id_ok) begin
      and_mem[idx] <= and_mask_i[N-1:0];
      or_mem[idx]  <= or_mask_i[N-1:0];
    end
    if (cmd_i.rd_en) begin
      and_rd_q <= and_mem[idx];
      or_rd_q  <= or_mem[idx];
      idx_q    <= idx;
      last_q   <= last_in_order_i;
    end
  end

  // Valid bits and their read, control flags of the latched item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      id_ok_q  <= 1'b0;
    end else begin
      if (cmd_i.load_we && id_ok) begin
        vld_q[idx] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        vld_rd_q <= vld_q[idx];
        id_ok_q  <= id_ok;
      end
    end
  end

  // Evaluate one check against the finished set
  always_comb begin
    logic               first;
    logic [N-1:0]       fin_b;
    aopc_pkg::verdict_e ff_b;
    logic [N-1:0]       am;
    logic [N-1:0]       om;

    first     = !mid_q;
    // start of an order clears its state
    fin_b     = first ? '0 : fin_q;
    ff_b      = first ? aopc_pkg::VerdictLegal : ff_q;
    zs_d      = first ? 1'b0 : zs_q;
    am        = vld_rd_q ? and_rd_q : '0;
    om        = vld_rd_q ? or_rd_q : '0;
    fin_d     = fin_b;
    ff_d      = ff_b;

    if (!id_ok_q) begin
      zs_d = 1'b1;
    end else if (ff_b == aopc_pkg::VerdictLegal) begin
      priority if (first) begin
        if ((am | om) != '0) ff_d = aopc_pkg::VerdictNotRoot;
      end else if ((om != '0) && ((om & fin_b) == '0)) begin
        ff_d = aopc_pkg::VerdictOrUnmet;
      end else if ((am & ~fin_b) != '0) begin
        ff_d = aopc_pkg::VerdictAndUnmet;
      end else begin
        // all predecessors met
        ff_d = ff_b;
      end
      if ((ff_d == aopc_pkg::VerdictLegal) || first) begin
        fin_d = fin_b | (N'(1) << idx_q);
      end
    end

    verdict_d = zs_d ? aopc_pkg::VerdictZero : ff_d;
  end

  // Order state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q     <= '0;
      ff_q      <= aopc_pkg::VerdictLegal;
      zs_q      <= 1'b0;
      mid_q     <= 1'b0;
      valid_q   <= 1'b0;
      verdict_q <= aopc_pkg::VerdictLegal;
    end else begin
      valid_q <= 1'b0;
      if (cmd_i.eval_en) begin
        fin_q   <= fin_d;
        ff_q    <= ff_d;
        zs_q    <= zs_d;
        mid_q   <= !last_q;
        valid_q <= last_q;
        if (last_q) verdict_q <= verdict_d;
      end
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;

  // Assertions
  a_valid_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(cmd_i.eval_en))
    else $error("result without evaluation");

  a_zero_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && zs_q) |-> (verdict_q == aopc_pkg::VerdictZero))
    else $error("zero id not reported");

  a_one_task_per_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(fin_q & ~$past(fin_q)) <= 1)
    else $error("more than one task finished in a cycle");

endmodule

@@ hw/rtl/and_or_precedence_checker.sv @@
// Sequence: a check item's masks are read into registers, then the item is
// evaluated in StEval and valid_o strobes from a register (when it ends an
// order); busy_o is high one cycle. Loads: one per cycle while busy_o is low;
// the registered table read makes a check block new items until evaluated.
// Reset: asynchronous, active low; tables read as empty, no order open.
// The receiver cannot stall: valid_o is a single-cycle strobe.
`timescale 1ns / 1ps

module and_or_precedence_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [aopc_pkg::TaskIdW-1:0]  task_id_i,
  input  logic [aopc_pkg::MaskW-1:0]    and_mask_i,
  input  logic [aopc_pkg::MaskW-1:0]    or_mask_i,
  input  logic                          last_in_order_i,
  output logic                          valid_o,
  output logic [aopc_pkg::VerdictW-1:0] verdict_o
);

  aopc_pkg::cmd_t cmd;

  // Controller
  aopc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd)
  );

  // Datapath
  aopc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .task_id_i       (task_id_i),
    .and_mask_i      (and_mask_i),
    .or_mask_i       (or_mask_i),
    .last_in_order_i (last_in_order_i),
    .valid_o         (valid_o),
    .verdict_o       (verdict_o)
  );

endmodule
